@@ design/motor_pot_position_controller_unit_defines.svh @@
// Assertion macros shared by the controller.
`ifndef MOTOR_POT_POSITION_CONTROLLER_UNIT_DEFINES_SVH
`define MOTOR_POT_POSITION_CONTROLLER_UNIT_DEFINES_SVH

// Assert that an antecedent implies a consequent on the next cycle.
`define MPPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Assert that a condition holds every cycle out of reset.
`define MPPC_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

`endif

@@ design/mppc_pkg.sv @@
package mppc_pkg;
   localparam int RAW_W = 10;
   localparam int OHM_W = 20;
   localparam int TIME_W = 32;
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SET_TARGET = 1'b1;
   localparam logic [2:0] REG_DIVIDER = 3'd0;
   localparam logic [2:0] REG_READ_LIMIT = 3'd1;
   localparam logic [2:0] REG_PWM_DIST = 3'd2;
   localparam logic [2:0] REG_DB_LOW = 3'd3;
   localparam logic [2:0] REG_DB_HIGH = 3'd4;
   localparam logic [2:0] REG_STALL_TMO = 3'd5;
   localparam logic [2:0] REG_STALL_MOVE = 3'd6;
   localparam logic [2:0] REG_FLAGS = 3'd7;
   localparam logic [1:0] GATE_OFF = 2'd0;
   localparam logic [1:0] GATE_INC = 2'd1;
   localparam logic [1:0] GATE_DEC = 2'd2;
   localparam logic [31:0] REPORT_HOLDOFF_MS = 32'd40;
   localparam logic [19:0] REPORT_BASE = 20'd12;
   localparam logic [11:0] REPORT_SCALE = 12'd2045;
   // numerator divider*(1024-raw) fits 30 bits
   localparam int NUM_W = 30;
endpackage

@@ design/motor_pot_position_controller_unit.sv @@
// Position controller for one motorized potentiometer. Each req item is a
// tick (operation 0: one millisecond with an ADC sample) or a set-target
// item (operation 1), and yields exactly one rsp item. A tick that samples
// converts the reading to ohms with a restoring divider that retires one
// quotient bit per cycle over the 30-bit numerator, so such an item passes
// through ST_MUL, ST_DIV, ST_EVAL and ST_CTRL before rsp_tvalid rises, and
// no further item is accepted before then; ticks that skip sampling and
// set-target items raise rsp_tvalid on the cycle after acceptance. The
// divider is the only multi-cycle unit; one item is in flight at a time,
// and req_tready is low while a finished rsp item waits with rsp_tready
// low. Configuration is written through csr_; the user must write it only
// while the block is idle, as the block itself does not enforce this.
`include "motor_pot_position_controller_unit_defines.svh"
module motor_pot_position_controller_unit
   import mppc_pkg::*;
#(
   parameter int ACCURACY_SPLIT = 5000,
   parameter int DIALIN_MS = 500,
   parameter int PWM_OFF_MS = 10,
   parameter int IDLE_MS = 100,
   parameter int TARGET_FLOOR = 0,
   parameter int TARGET_CEILING = 1000000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,    // operation
   input  logic [31:0] req_tdata,    // adc_sample[9:0], target_value[29:10],
                                     // other_motor_busy[30], buzzer_active[31]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // drive_increase[0], drive_decrease[1],
                                     // moving[2], online[3], stall_fault[4],
                                     // report_valid[5], report_position[25:6]
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_wdata
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL = 3'd1;
   localparam logic [2:0] ST_DIV = 3'd2;
   localparam logic [2:0] ST_EVAL = 3'd3;
   localparam logic [2:0] ST_CTRL = 3'd4;

   localparam logic [31:0] DIALIN_C = 32'(DIALIN_MS);
   localparam logic [31:0] PWM_C = 32'(PWM_OFF_MS);
   localparam logic [31:0] IDLE_C = 32'(IDLE_MS);
   localparam logic [19:0] SPLIT_C = 20'(ACCURACY_SPLIT);
   localparam logic [19:0] KLO_C = 20'(TARGET_FLOOR);
   localparam logic [20:0] KHI_C = 21'(TARGET_CEILING);

   logic [19:0] div_ff, lim_ff, pwmd_ff, smove_ff;
   logic [15:0] dbl_ff, dbh_ff, stmo_ff;
   logic [1:0]  flags_ff;

   logic [2:0]  state_ff, state_in;
   logic [31:0] now_ff, nst_ff, sdl_ff, ddl_ff, pdl_ff, rdl_ff;
   logic [19:0] tgt_ff, sref_ff, lrep_ff;
   logic        drv_ff, onl_ff;
   logic [1:0]  gate_ff;

   logic [9:0]  raw_ff;
   logic        busy_ff, buzz_ff;
   logic [NUM_W-1:0] num_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [10:0] rem_ff;
   logic [4:0]  cnt_ff;
   logic [19:0] r_ff;
   logic        ok_ff;

   logic        out_v_ff, fault_ff, rep_ff;
   logic [19:0] rpos_ff;

   logic req_acc, rsp_acc;
   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && !(out_v_ff && !rsp_tready);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {6'd0, rpos_ff, rep_ff, fault_ff, onl_ff, drv_ff,
                       gate_ff[1], gate_ff[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff <= 20'd10000; lim_ff <= 20'd100000; pwmd_ff <= 20'd1000;
         dbl_ff <= 16'd50; dbh_ff <= 16'd200; stmo_ff <= 16'd1000;
         smove_ff <= 20'd100; flags_ff <= 2'd1;
      end else if (csr_we) begin
         case (csr_index)
            REG_DIVIDER: div_ff <= csr_wdata;
            REG_READ_LIMIT: lim_ff <= csr_wdata;
            REG_PWM_DIST: pwmd_ff <= csr_wdata;
            REG_DB_LOW: dbl_ff <= csr_wdata[15:0];
            REG_DB_HIGH: dbh_ff <= csr_wdata[15:0];
            REG_STALL_TMO: stmo_ff <= csr_wdata[15:0];
            REG_STALL_MOVE: smove_ff <= csr_wdata;
            REG_FLAGS: flags_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // control math on the converted reading
   logic [20:0] r21, tg21, ref21, thr21;
   logic [20:0] tgt_dist, sdiff;
   logic [21:0] rsum;
   logic [31:0] th32;
   logic [21:0] rep_hi;
   logic        rep_lo, rep_go;
   logic [31:0] r_mul;
   always_comb begin
      r21 = {1'b0, r_ff};
      tg21 = {1'b0, tgt_ff};
      ref21 = {1'b0, sref_ff};
      thr21 = (tgt_ff < SPLIT_C) ? {5'd0, dbl_ff} : {5'd0, dbh_ff};
      tgt_dist = (tg21 > r21) ? tg21 - r21 : r21 - tg21;
      sdiff = (ref21 > r21) ? ref21 - r21 : r21 - ref21;
      rsum = {1'b0, ref21} + {1'b0, r21};
      r_mul = 32'(r_ff) * 32'(REPORT_SCALE);
      th32 = 32'(REPORT_BASE) + (r_mul >> 18);
      rep_hi = 22'(lrep_ff) + 22'(th32);
      rep_lo = (32'(lrep_ff) > th32) && (32'(r_ff) < 32'(lrep_ff) - th32);
      rep_go = flags_ff[0] && !drv_ff && (rep_lo || 22'(r_ff) > rep_hi) &&
               !buzz_ff && (now_ff > rdl_ff);
   end

   logic [11:0] trial;
   assign trial = {rem_ff, num_ff[NUM_W-1]} - 12'({2'b0, raw_ff});

   logic div_last;
   assign div_last = (state_ff == ST_DIV) && (cnt_ff == 5'(NUM_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
         now_ff <= '0; nst_ff <= '0; sdl_ff <= '0; ddl_ff <= '0;
         pdl_ff <= '0; rdl_ff <= '0; tgt_ff <= '0; sref_ff <= '0;
         lrep_ff <= '0; drv_ff <= 1'b0; onl_ff <= 1'b0; gate_ff <= GATE_OFF;
         fault_ff <= 1'b0; rep_ff <= 1'b0; rpos_ff <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  raw_ff <= req_tdata[9:0];
                  busy_ff <= req_tdata[30];
                  buzz_ff <= req_tdata[31];
                  fault_ff <= 1'b0; rep_ff <= 1'b0; rpos_ff <= '0;
                  if (req_tuser == OP_SET_TARGET) begin
                     if ({1'b0, req_tdata[29:10]} < KHI_C &&
                         req_tdata[29:10] > KLO_C)
                        tgt_ff <= req_tdata[29:10];
                     out_v_ff <= 1'b1;
                  end else begin
                     now_ff <= now_ff + 32'd1;
                     out_v_ff <= !(now_ff + 32'd1 > nst_ff);
                  end
               end else if (rsp_acc) begin
                  out_v_ff <= 1'b0;
               end
            end
            ST_MUL: begin
               num_ff <= NUM_W'(div_ff) * NUM_W'(11'd1024 - {1'b0, raw_ff});
               rem_ff <= '0; quo_ff <= '0; cnt_ff <= '0;
            end
            ST_DIV: begin
               num_ff <= {num_ff[NUM_W-2:0], 1'b0};
               cnt_ff <= cnt_ff + 5'd1;
               if (!trial[11]) begin
                  rem_ff <= trial[10:0];
                  quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[9:0], num_ff[NUM_W-1]};
                  quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
               end
            end
            ST_EVAL: begin
               r_ff <= (raw_ff == 10'd0) ? 20'd0 : quo_ff[19:0];
               ok_ff <= (raw_ff != 10'd0) && (quo_ff < NUM_W'(lim_ff));
            end
            ST_CTRL: begin
               out_v_ff <= 1'b1;
               if (!ok_ff) begin
                  nst_ff <= now_ff + IDLE_C;
                  onl_ff <= 1'b0;
               end else begin
                  onl_ff <= 1'b1;
                  if (rep_go) begin
                     rdl_ff <= now_ff + REPORT_HOLDOFF_MS;
                     lrep_ff <= r_ff; rep_ff <= 1'b1; rpos_ff <= r_ff;
                  end
                  if (tgt_ff != '0 && flags_ff[0] && !busy_ff) begin
                     if (sref_ff != '0 && now_ff > sdl_ff &&
                         (sdiff < 21'(smove_ff) || rsum < 22'(smove_ff))) begin
                        drv_ff <= 1'b0; gate_ff <= GATE_OFF; sdl_ff <= '0;
                        sref_ff <= '0; tgt_ff <= '0; fault_ff <= 1'b1;
                     end else begin
                        if (sref_ff == '0 || now_ff > sdl_ff) begin
                           sref_ff <= r_ff;
                           sdl_ff <= now_ff + 32'(stmo_ff);
                        end
                        if (tg21 > r21 + thr21 || tg21 + thr21 < r21) begin
                           drv_ff <= 1'b1;
                           if (tgt_dist <= 21'(pwmd_ff) && now_ff > pdl_ff) begin
                              pdl_ff <= now_ff + PWM_C;
                              gate_ff <= GATE_OFF;
                           end else begin
                              gate_ff <= (tg21 < r21) ? GATE_DEC : GATE_INC;
                           end
                           ddl_ff <= now_ff + DIALIN_C;
                        end else if (!(flags_ff[1] && now_ff < ddl_ff)) begin
                           drv_ff <= 1'b0; gate_ff <= GATE_OFF; sdl_ff <= '0;
                           sref_ff <= '0; tgt_ff <= '0;
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (req_acc && req_tuser == OP_TICK && now_ff + 32'd1 > nst_ff)
               state_in = ST_MUL;
         ST_MUL: state_in = ST_DIV;
         ST_DIV: if (div_last) state_in = ST_EVAL;
         ST_EVAL: state_in = ST_CTRL;
         ST_CTRL: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   `MPPC_ASSERT_ALWAYS(a_gate_excl, clock, reset, !(gate_ff[0] && gate_ff[1]))
   `MPPC_ASSERT_NEXT(a_div_done, clock, reset, div_last, state_ff == ST_EVAL)
   `MPPC_ASSERT_ALWAYS(a_rep_pos, clock, reset, rep_ff || rpos_ff == '0)
   `MPPC_ASSERT_ALWAYS(a_gate_drv, clock, reset, gate_ff == GATE_OFF || drv_ff)
endmodule
